>>> rtl/core/bdq_pkg.sv
// Package for the bounded deque: sizes, operation and status codes,
// transfer structs and the command broadcast to the cell chain.
// Has no dependencies; every other file imports it.
`timescale 1ns / 1ps

package bdq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_READ_ALL   = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] data_out;
    logic [1:0]         status;
    logic               last;
    logic [4:0]         occupancy;
  } out_item_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT_FRONT,
    CELL_LOAD_TAIL,
    CELL_SHIFT_FRONT,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic signed [31:0] din;
    logic signed [31:0] wrap;
    logic [CNT_W-1:0]   count;
  } cell_cmd_t;

endpackage

>>> rtl/core/bdq_cell.sv
// One cell of the deque chain: holds a single entry and takes data from
// its left or right neighbor or from the command, as the broadcast command says.
// Depends on bdq_pkg.
`timescale 1ns / 1ps

module bdq_cell
  import bdq_pkg::*;
(
  input  logic               clk,
  input  logic [IDX_W-1:0]   idx,
  input  cell_cmd_t          cmd,
  input  logic signed [31:0] left,
  input  logic signed [31:0] right,
  output logic signed [31:0] q
);

  logic signed [31:0] data_r;
  logic signed [31:0] data_nxt;
  logic [CNT_W-1:0]   pos;
  logic [CNT_W-1:0]   pos_plus;

  assign pos      = CNT_W'(idx);
  assign pos_plus = CNT_W'(idx) + CNT_W'(1);

  always_comb begin
    data_nxt = data_r;
    unique case (cmd.op)
      CELL_HOLD: data_nxt = data_r;
      CELL_INSERT_FRONT: begin
        data_nxt = (idx == '0) ? cmd.din : left;
      end
      CELL_LOAD_TAIL: begin
        if (pos == cmd.count) data_nxt = cmd.din;
      end
      CELL_SHIFT_FRONT: data_nxt = right;
      CELL_ROTATE: begin
        if (pos_plus == cmd.count) begin
          data_nxt = cmd.wrap;
        end else if (pos_plus < cmd.count) begin
          data_nxt = right;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

>>> rtl/core/bounded_deque_top.sv
// Top level of the bounded deque: control, entry count and the chain of
// DEPTH cells that holds the entries in order, front in cell zero.
// Depends on bdq_pkg and bdq_cell.
//
//   channel  ports                        transfer when
//   input    start, busy, in_item         start high and busy low at a clock edge
//   output   out_valid, out_item          out_valid high, for exactly one cycle
//
// A push, pop or unused opcode does not raise busy; its result is shown in the
// next cycle and a new item may be started in that same cycle.
// A read-out keeps busy high until it has sent out every entry held, one
// result per cycle, as the chain rotates by one cell each cycle.
// Reset is synchronous and clears the count and control; entries need none.
// The receiver cannot stall results.
`timescale 1ns / 1ps

module bounded_deque_top
  import bdq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   remain_r, remain_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  cell_cmd_t          cmd;
  logic signed [31:0] q [DEPTH];
  logic signed [31:0] left_in [DEPTH];
  logic signed [31:0] right_in [DEPTH];
  logic               accept;
  logic               full;
  logic               empty;
  logic [CNT_W-1:0]   tail_pos;

  assign accept   = start && (state_r == S_IDLE);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign tail_pos = count_r - CNT_W'(1);

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_chain
      if (g == 0) begin : g_first
        assign left_in[g] = cmd.din;
      end else begin : g_mid
        assign left_in[g] = q[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign right_in[g] = '0;
      end else begin : g_inner
        assign right_in[g] = q[g+1];
      end
      bdq_cell u_cell (
        .clk   (clk),
        .idx   (IDX_W'(g)),
        .cmd   (cmd),
        .left  (left_in[g]),
        .right (right_in[g]),
        .q     (q[g])
      );
    end
  endgenerate

  always_comb begin
    cmd.op    = CELL_HOLD;
    cmd.din   = in_item.data_in;
    cmd.wrap  = q[0];
    cmd.count = count_r;

    state_nxt     = state_r;
    count_nxt     = count_r;
    remain_nxt    = remain_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt         = 1'b1;
          out_item_nxt.data_out = '0;
          out_item_nxt.status   = ST_OK;
          out_item_nxt.last     = 1'b1;
          unique case (in_item.opcode)
            OP_PUSH_FRONT: begin
              if (full) begin
                out_item_nxt.status = ST_FULL;
              end else begin
                cmd.op    = CELL_INSERT_FRONT;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_PUSH_BACK: begin
              if (full) begin
                out_item_nxt.status = ST_FULL;
              end else begin
                cmd.op    = CELL_LOAD_TAIL;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                out_item_nxt.status = ST_EMPTY;
              end else begin
                cmd.op                = CELL_SHIFT_FRONT;
                out_item_nxt.data_out = q[0];
                count_nxt             = count_r - CNT_W'(1);
              end
            end
            OP_POP_BACK: begin
              if (empty) begin
                out_item_nxt.status = ST_EMPTY;
              end else begin
                out_item_nxt.data_out = q[tail_pos[IDX_W-1:0]];
                count_nxt             = count_r - CNT_W'(1);
              end
            end
            OP_READ_ALL: begin
              if (empty) begin
                out_item_nxt.status = ST_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                remain_nxt    = count_r;
                state_nxt     = S_READ;
              end
            end
            default: begin
              out_item_nxt.status = ST_OK;
            end
          endcase
          out_item_nxt.occupancy = 5'(count_nxt);
        end
      end
      S_READ: begin
        cmd.op                 = CELL_ROTATE;
        out_valid_nxt          = 1'b1;
        out_item_nxt.data_out  = q[0];
        out_item_nxt.status    = ST_OK;
        out_item_nxt.last      = (remain_r == CNT_W'(1));
        out_item_nxt.occupancy = 5'(count_r);
        remain_nxt             = remain_r - CNT_W'(1);
        if (remain_r == CNT_W'(1)) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r == S_READ);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_item.opcode != OP_READ_ALL) |=> out_valid && out_item.last)
    else $error("single operation did not give one last result");

  a_remain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (remain_r != '0) && (remain_r <= count_r))
    else $error("read-out counter out of range");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  a_read_end: assert property (@(posedge clk) disable iff (!rst_n)
    busy && (remain_r == CNT_W'(1)) |=> !busy && out_valid && out_item.last)
    else $error("read-out did not end with a last result");

endmodule

>>> bench/deque_scoreboard_pkg.sv
// Scoreboard class for the bounded deque testbench: a behavioral deque that
// turns each accepted command into expected results, and the result checker.
// Depends on bdq_pkg for the transfer structs, sizes and codes.
`timescale 1ns / 1ps

package deque_scoreboard_pkg;
  import bdq_pkg::*;

  class deque_scoreboard;
    logic signed [31:0] entries [DEPTH];
    int front_pos;
    int held;
    out_item_t expected_q [$];
    int mismatches;

    function new();
      front_pos = 0;
      held = 0;
      mismatches = 0;
    endfunction

    function void add_result(logic signed [31:0] value, logic [1:0] status, logic last);
      out_item_t r;
      r.data_out = value;
      r.status = status;
      r.last = last;
      r.occupancy = held[4:0];
      expected_q.push_back(r);
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) begin
        $display("MISMATCH at %0t: %s", $realtime, what);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_transfer(in_item_t item);
      logic signed [31:0] value;
      case (item.opcode)
        OP_PUSH_FRONT: begin
          if (held >= DEPTH) begin
            add_result('0, ST_FULL, 1'b1);
          end else begin
            front_pos = (front_pos + DEPTH - 1) % DEPTH;
            entries[front_pos] = item.data_in;
            held++;
            add_result('0, ST_OK, 1'b1);
          end
        end
        OP_PUSH_BACK: begin
          if (held >= DEPTH) begin
            add_result('0, ST_FULL, 1'b1);
          end else begin
            entries[(front_pos + held) % DEPTH] = item.data_in;
            held++;
            add_result('0, ST_OK, 1'b1);
          end
        end
        OP_POP_FRONT: begin
          if (held == 0) begin
            add_result('0, ST_EMPTY, 1'b1);
          end else begin
            value = entries[front_pos];
            front_pos = (front_pos + 1) % DEPTH;
            held--;
            add_result(value, ST_OK, 1'b1);
          end
        end
        OP_POP_BACK: begin
          if (held == 0) begin
            add_result('0, ST_EMPTY, 1'b1);
          end else begin
            value = entries[(front_pos + held - 1) % DEPTH];
            held--;
            add_result(value, ST_OK, 1'b1);
          end
        end
        OP_READ_ALL: begin
          if (held == 0) begin
            add_result('0, ST_EMPTY, 1'b1);
          end else begin
            for (int k = 0; k < held; k++) begin
              add_result(entries[(front_pos + k) % DEPTH], ST_OK, k == held - 1);
            end
          end
        end
        default: begin
          add_result('0, ST_OK, 1'b1);
        end
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        flag($sformatf("unexpected result data_out=%0d status=%0d last=%0d occupancy=%0d",
                       got.data_out, got.status, got.last, got.occupancy));
        return;
      end
      want = expected_q.pop_front();
      if (got.data_out !== want.data_out || got.status !== want.status ||
          got.last !== want.last || got.occupancy !== want.occupancy) begin
        flag($sformatf({"expected data_out=%0d status=%0d last=%0d occupancy=%0d, ",
                        "got data_out=%0d status=%0d last=%0d occupancy=%0d"},
                       want.data_out, want.status, want.last, want.occupancy,
                       got.data_out, got.status, got.last, got.occupancy));
      end
    endfunction
  endclass

endpackage

>>> bench/bounded_deque_top_tb.sv
// Top-level testbench for bounded_deque_top: directed corner cases, then
// phased random push/pop/read-out and unused-opcode traffic with random sender gaps.
// Depends on bdq_pkg, deque_scoreboard_pkg and the bounded_deque_top RTL.
`timescale 1ns / 1ps

module bounded_deque_top_tb;
  import bdq_pkg::*;
  import deque_scoreboard_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_ITEMS = 250;
  localparam int QUIET_TAIL = 60;
  localparam int PHASE_LEN = 40;
  localparam logic [2:0] OP_NOP_FIRST = 3'd5;
  localparam logic [2:0] OP_NOP_LAST = 3'd7;

  typedef enum int {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} phase_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic out_valid;
  in_item_t in_item;
  out_item_t out_item;

  deque_scoreboard sb;
  int cycle_count = 0;
  int accepted_items = 0;
  bit idling_on;
  phase_t phase;

  always #6 clk = ~clk;

  bounded_deque_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (rst_n) begin
      if (out_valid) begin
        sb.check_result(out_item);
      end
      if (start && !busy) begin
        sb.note_transfer(in_item);
        accepted_items++;
      end
    end
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_command(logic [2:0] op, logic signed [31:0] value);
    int gap;
    int seen;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      in_item.data_in = $urandom();
      gap = $urandom_range(1, 16);
      repeat (gap) @(negedge clk);
    end
    in_item.opcode = op;
    in_item.data_in = value;
    start = 1'b1;
    seen = accepted_items;
    do @(negedge clk); while (accepted_items == seen);
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [2:0] pick_opcode(phase_t ph);
    int r;
    int push_pct;
    r = $urandom_range(0, 99);
    case (ph)
      PHASE_FILL: push_pct = 75;
      PHASE_DRAIN: push_pct = 25;
      default: push_pct = 50;
    endcase
    if (r < 3) begin
      return 3'($urandom_range(OP_NOP_FIRST, OP_NOP_LAST));
    end else if (r < 12) begin
      return OP_READ_ALL;
    end else if ($urandom_range(0, 99) < push_pct) begin
      return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    end else begin
      return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
    end
  endfunction

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    idling_on = 1'b1;
    sb = new();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_command(OP_READ_ALL, '0);
    send_command(OP_POP_FRONT, '0);
    send_command(OP_POP_BACK, '0);
    send_command(OP_PUSH_BACK, 32'sd12345);
    send_command(OP_POP_BACK, '0);
    send_command(OP_PUSH_BACK, 32'sh7fffffff);
    send_command(OP_PUSH_FRONT, 32'sh80000000);
    send_command(OP_PUSH_BACK, '0);
    send_command(OP_PUSH_FRONT, -32'sd1);
    while (sb.held < DEPTH) begin
      send_command($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom());
    end
    send_command(OP_PUSH_FRONT, 32'sd1);
    send_command(OP_PUSH_BACK, 32'sd2);
    send_command(OP_READ_ALL, '0);
    for (int op = OP_NOP_FIRST; op <= OP_NOP_LAST; op++) begin
      send_command(3'(op), $urandom());
    end
    send_command(OP_POP_FRONT, '0);
    send_command(OP_POP_BACK, '0);
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % PHASE_LEN == 0) begin
        if (i > 0 && $urandom_range(0, 1) == 1) begin
          wait_drained();
        end
        phase = phase_t'((i / PHASE_LEN) % 3);
      end
      idling_on = (i < RANDOM_ITEMS - QUIET_TAIL) && ((i / 20) % 4 != 3);
      send_command(pick_opcode(phase), pick_value());
    end

    wait_drained();
    repeat (40) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
